[hw/rtl/soc_pkg.sv]
// Shared types and constants for the segment overlap counter.
// Used by soc_walker, soc_cover, segment_overlap_counter and the testbench; depends on nothing.
package soc_pkg;

  // Width of one coordinate field on the ports.
  localparam int unsigned FieldW = 10;

  // Running total width and its saturation value.
  localparam int unsigned TotalW = 21;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Per-cell coverage counter: saturates at three, overlap counted on reaching two.
  localparam logic [1:0] CntSat       = 2'd3;
  localparam logic [1:0] OverlapLevel = 2'd2;

  // Step pattern of the cell walk.
  typedef struct packed {
    logic x_en;
    logic x_up;
    logic y_en;
    logic y_up;
  } step_t;

  // Status of the coverage store toward the sequencer.
  typedef struct packed {
    logic ready;  // clearing pass finished
    logic done;   // last cell of a segment written back
  } cov_stat_t;

  // Top level control states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } soc_state_e;

endpackage

[hw/rtl/soc_walker.sv]
// Cell walker: turns one segment into a stream of grid cell addresses, one per cycle.
// Depends on soc_pkg.
module soc_walker import soc_pkg::*; #(
  parameter int unsigned CoordW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CoordW-1:0]   x1_i,
  input  logic [CoordW-1:0]   y1_i,
  input  logic [CoordW-1:0]   x2_i,
  input  logic [CoordW-1:0]   y2_i,
  output logic                cell_valid_o,
  output logic                cell_last_o,
  output logic [2*CoordW-1:0] cell_addr_o
);

  logic              busy_q, busy_d;
  logic [CoordW-1:0] x_q, x_d;
  logic [CoordW-1:0] y_q, y_d;
  logic [CoordW-1:0] cnt_q, cnt_d;
  step_t             step_q, step_d;

  logic              x_lt, y_lt;
  logic [CoordW-1:0] x_span, y_span;
  logic              last;

  // Span and direction of the new segment.
  assign x_lt   = x1_i < x2_i;
  assign y_lt   = y1_i < y2_i;
  assign x_span = x_lt ? (x2_i - x1_i) : (x1_i - x2_i);
  assign y_span = y_lt ? (y2_i - y1_i) : (y1_i - y2_i);

  assign last = (cnt_q == '0);

  // Load on start, otherwise step one cell per cycle until the count runs out.
  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      if (y1_i == y2_i) begin
        // Horizontal, including a single point: walk x upward from the low end.
        x_d    = x_lt ? x1_i : x2_i;
        y_d    = y1_i;
        cnt_d  = x_span;
        step_d = '{x_en: 1'b1, x_up: 1'b1, y_en: 1'b0, y_up: 1'b0};
      end else if (x1_i == x2_i) begin
        // Vertical: walk y upward from the low end.
        x_d    = x1_i;
        y_d    = y_lt ? y1_i : y2_i;
        cnt_d  = y_span;
        step_d = '{x_en: 1'b0, x_up: 1'b0, y_en: 1'b1, y_up: 1'b1};
      end else begin
        // Slanted: x span sets the length, y wraps around the grid.
        x_d    = x1_i;
        y_d    = y1_i;
        cnt_d  = x_span;
        step_d = '{x_en: 1'b1, x_up: x_lt, y_en: 1'b1, y_up: y_lt};
      end
    end else if (busy_q) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (step_q.x_en) begin
          x_d = step_q.x_up ? (x_q + 1'b1) : (x_q - 1'b1);
        end
        if (step_q.y_en) begin
          y_d = step_q.y_up ? (y_q + 1'b1) : (y_q - 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    cnt_q  <= cnt_d;
    step_q <= step_d;
  end

  assign cell_valid_o = busy_q;
  assign cell_last_o  = last;
  assign cell_addr_o  = {y_q, x_q};

endmodule

[hw/rtl/soc_cover.sv]
// Coverage store: one two-bit saturating counter per cell in a synchronous RAM,
// read-modify-write per cell, plus the running overlap total. Depends on soc_pkg.
module soc_cover import soc_pkg::*; #(
  parameter int unsigned CoordW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cell_valid_i,
  input  logic                cell_last_i,
  input  logic [2*CoordW-1:0] cell_addr_i,
  output cov_stat_t           stat_o,
  output logic [TotalW-1:0]   total_o
);

  localparam int unsigned AddrW = 2 * CoordW;
  localparam int unsigned Cells = 1 << AddrW;

  logic [1:0] cover_mem [Cells];

  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  logic             s1_valid_q;
  logic             s1_last_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [1:0]       rd_q;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [1:0]        wr_data;
  logic [1:0]        cnt_inc;
  logic [TotalW-1:0] total_q, total_d;

  // Clearing pass after reset: one entry per cycle over the whole store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {AddrW{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Read stage: the counter comes back in the cycle after the address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cell_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= cell_last_i;
    s1_addr_q <= cell_addr_i;
  end

  // Update stage. Cells of one segment are all distinct and segments are
  // separated by the sequencer, so a write never meets a read of the same cell.
  assign cnt_inc = rd_q + 2'd1;
  assign wr_en   = clr_busy_q || (s1_valid_q && (rd_q != CntSat));
  assign wr_addr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign wr_data = clr_busy_q ? 2'd0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cover_mem[wr_addr] <= wr_data;
    end
    if (cell_valid_i) begin
      rd_q <= cover_mem[cell_addr_i];
    end
  end

  // Running total counts each cell once, when its counter reaches two.
  always_comb begin
    total_d = total_q;
    if (s1_valid_q && (rd_q != CntSat) && (cnt_inc == OverlapLevel) &&
        (total_q != TotalMax)) begin
      total_d = total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  assign stat_o.ready = !clr_busy_q;
  assign stat_o.done  = s1_valid_q && s1_last_q;
  assign total_o      = total_q;

  // No cell may be walked while the clearing pass still owns the write port.
  a_no_cell_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid_i |-> !clr_busy_q)
    else $error("cell issued during clearing pass");

  // A read never hits the cell being written back in the same cycle.
  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid_i && s1_valid_q) |-> (cell_addr_i != s1_addr_q))
    else $error("read and write-back to the same cell overlap");

  // The total only grows, by at most one per cycle.
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((total_q == $past(total_q)) || (total_q == $past(total_q) + 1'b1)))
    else $error("overlap total moved by more than one");

endmodule

[hw/rtl/segment_overlap_counter.sv]
// A segment covering N cells passes the walker, then the store's read and update stages
// with one read-modify-write per cell on separate RAM read and write ports, then the
// output register; a new segment is taken only after the previous total is loaded there.
// N is up to 2^COORD_BITS (1024 by default). Reset: the whole coverage store is cleared
// one cell per cycle, with input stalled; total and control registers reset at once.
// Top level of the segment overlap counter; depends on soc_pkg, soc_walker and soc_cover.
module segment_overlap_counter import soc_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FieldW-1:0] start_x_i,
  input  logic [FieldW-1:0] start_y_i,
  input  logic [FieldW-1:0] end_x_i,
  input  logic [FieldW-1:0] end_y_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TotalW-1:0] overlap_total_o
);

  localparam int unsigned AddrW = 2 * COORD_BITS;

  soc_state_e state_q, state_d;

  logic                    in_fire;
  logic                    out_free;
  logic                    out_load;
  logic                    out_valid_q, out_valid_d;
  logic [TotalW-1:0]       out_total_q;

  logic                    cell_valid;
  logic                    cell_last;
  logic [AddrW-1:0]        cell_addr;
  cov_stat_t               cov_stat;
  logic [TotalW-1:0]       total;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Segment walk: only the low COORD_BITS of each coordinate are used.
  soc_walker #(
    .CoordW (COORD_BITS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_fire),
    .x1_i         (COORD_BITS'(start_x_i)),
    .y1_i         (COORD_BITS'(start_y_i)),
    .x2_i         (COORD_BITS'(end_x_i)),
    .y2_i         (COORD_BITS'(end_y_i)),
    .cell_valid_o (cell_valid),
    .cell_last_o  (cell_last),
    .cell_addr_o  (cell_addr)
  );

  soc_cover #(
    .CoordW (COORD_BITS)
  ) u_cover (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_valid),
    .cell_last_i  (cell_last),
    .cell_addr_i  (cell_addr),
    .stat_o       (cov_stat),
    .total_o      (total)
  );

  // Sequencer: clear, accept one segment, walk it, hand the total to the output register.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (cov_stat.ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cov_stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register: holds the beat until the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_total_q <= total;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign overlap_total_o = out_total_q;

  // The store reports a finished segment only while the sequencer is walking one.
  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cov_stat.done |-> (state_q == ST_WALK))
    else $error("segment completion outside of a walk");

  // Cells are issued only while a segment is being walked.
  a_cell_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid |-> (state_q == ST_WALK))
    else $error("cell issued outside of a walk");

endmodule

[dv/tb_segment_overlap_counter.sv]
// Self-checking testbench for segment_overlap_counter. It drives line segments, tracks the
// expected overlap total on its own coverage grid, and checks every result beat in order.
// Depends on soc_pkg and the segment_overlap_counter RTL.
module tb_segment_overlap_counter;
  import soc_pkg::*;

  localparam int unsigned GridBits    = 10;
  localparam int unsigned GridMask    = (1 << GridBits) - 1;
  localparam int unsigned CellCount   = 1 << (2 * GridBits);
  localparam int unsigned NumDir      = 17;
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned PerPhase    = 112;
  localparam int unsigned NumClusters = 4;
  localparam int unsigned Win         = 32;
  localparam int unsigned DrainCycles = 1100;
  localparam longint unsigned CycleLimit = 64'd8_000_000;

  // Idle and stall percentages per random phase.
  localparam int unsigned SendPct [NumPhases] = '{0, 63, 0, 35, 0};
  localparam int unsigned RecvPct [NumPhases] = '{0, 0, 63, 35, 0};

  typedef struct packed {
    logic [FieldW-1:0] sx;
    logic [FieldW-1:0] sy;
    logic [FieldW-1:0] ex;
    logic [FieldW-1:0] ey;
  } seg_t;

  typedef struct packed {
    seg_t              seg;
    logic              known;
    logic [TotalW-1:0] total;
  } dir_row_t;

  // Directed segments. A total is typed in only where it is obvious; the rest use the
  // predictor.
  localparam dir_row_t DirRows [NumDir] = '{
    // Single point after reset, then covered again up to saturation.
    '{'{10'd5, 10'd5, 10'd5, 10'd5}, 1'b1, 21'd0},
    '{'{10'd5, 10'd5, 10'd5, 10'd5}, 1'b1, 21'd1},
    '{'{10'd5, 10'd5, 10'd5, 10'd5}, 1'b1, 21'd1},
    '{'{10'd5, 10'd5, 10'd5, 10'd5}, 1'b1, 21'd1},
    // Full bottom row, then the same row reversed: every cell reaches two.
    '{'{10'd0, 10'd0, 10'd1023, 10'd0}, 1'b1, 21'd1},
    '{'{10'd1023, 10'd0, 10'd0, 10'd0}, 1'b1, 21'd1025},
    // Full columns at both edges, one reversed.
    '{'{10'd1023, 10'd0, 10'd1023, 10'd1023}, 1'b0, 21'd0},
    '{'{10'd0, 10'd1023, 10'd0, 10'd0}, 1'b0, 21'd0},
    // Both full diagonals.
    '{'{10'd0, 10'd0, 10'd1023, 10'd1023}, 1'b0, 21'd0},
    '{'{10'd1023, 10'd0, 10'd0, 10'd1023}, 1'b0, 21'd0},
    // Full top row.
    '{'{10'd0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, 21'd0},
    // Slanted with a short y span: y wraps over the top edge, then under the bottom one.
    '{'{10'd100, 10'd1021, 10'd106, 10'd1023}, 1'b0, 21'd0},
    '{'{10'd300, 10'd2, 10'd292, 10'd0}, 1'b0, 21'd0},
    // Slanted with a long y span, then a short diagonal walked downward in x and y.
    '{'{10'd10, 10'd10, 10'd12, 10'd500}, 1'b0, 21'd0},
    '{'{10'd12, 10'd12, 10'd10, 10'd10}, 1'b0, 21'd0},
    // Short reversed horizontal and a vertical through the saturated point.
    '{'{10'd7, 10'd5, 10'd3, 10'd5}, 1'b0, 21'd0},
    '{'{10'd5, 10'd3, 10'd5, 10'd9}, 1'b0, 21'd0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [FieldW-1:0] start_x_i;
  logic [FieldW-1:0] start_y_i;
  logic [FieldW-1:0] end_x_i;
  logic [FieldW-1:0] end_y_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [TotalW-1:0] overlap_total_o;

  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       err_cnt        = 0;
  longint unsigned   cycle_cnt;
  int unsigned       clus_x [NumClusters];
  int unsigned       clus_y [NumClusters];

  // Predicted coverage grid, running total and the totals still to arrive.
  bit [1:0]          cell_cov [CellCount];
  logic [TotalW-1:0] cov_total = '0;
  logic [TotalW-1:0] pending_totals [$];

  segment_overlap_counter #(
    .COORD_BITS(GridBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .overlap_total_o(overlap_total_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_cnt++;
  endtask

  // Bumps one cell's saturating counter and counts the step from one to two.
  function automatic void bump_cell(input int unsigned x, input int unsigned y);
    int unsigned idx;
    idx = ((y & GridMask) << GridBits) | (x & GridMask);
    if (cell_cov[idx] != CntSat) begin
      cell_cov[idx] = cell_cov[idx] + 2'd1;
      if (cell_cov[idx] == OverlapLevel && cov_total != TotalMax) begin
        cov_total = cov_total + 1'b1;
      end
    end
  endfunction

  // Rasterizes one segment into the grid and returns the new overlap total.
  function automatic logic [TotalW-1:0] cover_segment(input seg_t s);
    int unsigned x1, y1, x2, y2, lo, hi, span, i;
    bit          up_x, up_y;
    x1 = 32'(s.sx) & GridMask;
    y1 = 32'(s.sy) & GridMask;
    x2 = 32'(s.ex) & GridMask;
    y2 = 32'(s.ey) & GridMask;
    if (y1 == y2) begin
      lo = (x1 < x2) ? x1 : x2;
      hi = (x1 < x2) ? x2 : x1;
      for (i = lo; i <= hi; i++) bump_cell(i, y1);
    end else if (x1 == x2) begin
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      for (i = lo; i <= hi; i++) bump_cell(x1, i);
    end else begin
      // One step in x and one in y per cell; y wraps through the mask.
      up_x = x1 < x2;
      up_y = y1 < y2;
      span = up_x ? x2 - x1 : x1 - x2;
      for (i = 0; i <= span; i++) begin
        bump_cell(up_x ? x1 + i : x1 - i, up_y ? y1 + i : y1 - i);
      end
    end
    return cov_total;
  endfunction

  // Random segment: mostly short ones in a few crowded windows, some that wrap in y,
  // and some spanning the whole grid.
  function automatic seg_t rand_segment();
    seg_t        s;
    int unsigned r, k, bx, by, d, len;
    r = $urandom_range(99);
    if (r < 60) begin
      k  = $urandom_range(NumClusters - 1);
      bx = clus_x[k];
      by = clus_y[k];
      s.sx = FieldW'(bx + $urandom_range(Win - 1));
      s.sy = FieldW'(by + $urandom_range(Win - 1));
      s.ex = FieldW'(bx + $urandom_range(Win - 1));
      s.ey = FieldW'(by + $urandom_range(Win - 1));
      case ($urandom_range(4))
        0: s.ey = s.sy;
        1: s.ex = s.sx;
        2: begin
          // True diagonal in either y direction.
          d = (s.ex > s.sx) ? 32'(s.ex - s.sx) : 32'(s.sx - s.ex);
          s.ey = $urandom_range(1) ? FieldW'(32'(s.sy) + d) : FieldW'(32'(s.sy) - d);
        end
        3: ;
        default: begin
          s.ex = s.sx;
          s.ey = s.sy;
        end
      endcase
    end else if (r < 75) begin
      // Slanted with a y span shorter than the x span, crossing the top or bottom edge.
      len  = $urandom_range(20, 2);
      s.sx = FieldW'($urandom_range(GridMask - len));
      s.ex = FieldW'(32'(s.sx) + len);
      if ($urandom_range(1)) begin
        s.sx = s.ex;
        s.ex = FieldW'(32'(s.ex) - len);
      end
      d = $urandom_range(len - 1, 1);
      if ($urandom_range(1)) begin
        s.sy = FieldW'(GridMask - d);
        s.ey = FieldW'(GridMask);
      end else begin
        s.sy = FieldW'(d);
        s.ey = '0;
      end
    end else begin
      s.sx = FieldW'($urandom_range(GridMask));
      s.sy = FieldW'($urandom_range(GridMask));
      s.ex = FieldW'($urandom_range(GridMask));
      s.ey = FieldW'($urandom_range(GridMask));
      case ($urandom_range(2))
        0: s.ey = s.sy;
        1: s.ex = s.sx;
        default: ;
      endcase
    end
    return s;
  endfunction

  // Offers one segment beat, waits for it to be taken, then records its expected total.
  task automatic send_segment(input seg_t s, input logic known,
                              input logic [TotalW-1:0] known_total);
    logic [TotalW-1:0] predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= s.sx;
    start_y_i  <= s.sy;
    end_x_i    <= s.ex;
    end_y_i    <= s.ey;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = cover_segment(s);
    pending_totals.push_back(known ? known_total : predicted);
  endtask

  // Holds the sender off until every expected total has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result check against the oldest expected total.
  always @(posedge clk_i) begin : total_check
    logic [TotalW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_totals.size() == 0) begin
        report_mismatch($sformatf("total beat %0d with none expected", overlap_total_o));
      end else begin
        want = pending_totals.pop_front();
        if (overlap_total_o !== want) begin
          report_mismatch($sformatf("overlap_total got %0d, want %0d",
                                    overlap_total_o, want));
        end
      end
    end
  end

  // Cycle limit; allows for the clearing pass after reset.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // Reset, directed segments, then random phases with varying idle and stall rates.
  initial begin : stimulus
    int unsigned n, p;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    start_x_i  <= '0;
    start_y_i  <= '0;
    end_x_i    <= '0;
    end_y_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < NumDir; n++) begin
      send_segment(DirRows[n].seg, DirRows[n].known, DirRows[n].total);
    end
    wait_drained();

    for (n = 0; n < NumClusters; n++) begin
      clus_x[n] = $urandom_range(GridMask - 2 * Win, Win);
      clus_y[n] = $urandom_range(GridMask - 2 * Win, Win);
    end

    for (p = 0; p < NumPhases; p++) begin
      send_idle_pct  = SendPct[p];
      recv_stall_pct = RecvPct[p];
      for (n = 0; n < PerPhase; n++) begin
        send_segment(rand_segment(), 1'b0, '0);
      end
      wait_drained();
    end

    // Give a stray late beat time to show up.
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/soc_pkg.sv
hw/rtl/soc_walker.sv
hw/rtl/soc_cover.sv
hw/rtl/segment_overlap_counter.sv
dv/tb_segment_overlap_counter.sv
